FILE: hw/rtl/d3r_pkg.sv
package d3r_pkg;

  // Fixed field widths
  localparam int unsigned DISP_W         = 16;
  localparam int unsigned DISP_FRAC_BITS = 4;
  localparam int unsigned CENTER_W       = 16;
  localparam int unsigned CENTER_FRAC    = 4;
  localparam int unsigned MIN_DISP_W     = 8;
  localparam int unsigned FOCAL_W        = 24;
  localparam int unsigned BASE_W         = 24;
  localparam int unsigned K_FRAC_BITS    = 8;
  localparam int unsigned K_W            = BASE_W + DISP_FRAC_BITS;
  localparam int unsigned COORD_OUT_W    = 32;
  localparam int unsigned CFG_IDX_W      = 8;
  localparam int unsigned CFG_DATA_W     = 24;

  // Accumulator: up to 2^25-1 depths of 32 bits each
  localparam int unsigned COUNT_W   = 25;
  localparam int unsigned SUM_W     = COUNT_W + COORD_OUT_W;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Divider: 32 quotient bits, partial remainder as wide as the divisor
  localparam int unsigned QUO_W  = 32;
  localparam int unsigned STEP_W = $clog2(QUO_W);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_DISP = 8'd0,
    CFG_FOCAL    = 8'd1,
    CFG_CENTER_X = 8'd2,
    CFG_CENTER_Y = 8'd3,
    CFG_BASELINE = 8'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_KDIV,
    ST_MUL,
    ST_SAT,
    ST_FRAME,
    ST_MDIV,
    ST_OUT
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic div_k_start;
    logic div_mean_start;
    logic k_load;
    logic mul_load;
    logic sat_load;
    logic mean_load;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pt_valid;
    logic last;
    logic count_nz;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

FILE: hw/rtl/d3r_div.sv
module d3r_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [d3r_pkg::COUNT_W-1:0]    rem_init_i,
  input  logic [d3r_pkg::QUO_W-1:0]      dividend_i,
  input  logic [d3r_pkg::COUNT_W-1:0]    divisor_i,
  output logic                           done_o,
  output logic [d3r_pkg::QUO_W-1:0]      quotient_o
);
  import d3r_pkg::*;

  logic                  busy_q;
  logic                  done_q;
  logic [STEP_W-1:0]     step_q;
  logic [COUNT_W-1:0]    rem_q, rem_d;
  logic [COUNT_W-1:0]    divisor_q;
  logic [QUO_W-1:0]      work_q;
  logic [COUNT_W:0]      trial;
  logic [COUNT_W:0]      diff;
  logic                  qbit;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_q, work_q[QUO_W-1]};
    diff  = trial - {1'b0, divisor_q};
    qbit  = ~diff[COUNT_W];
    if (qbit) begin
      rem_d = diff[COUNT_W-1:0];
    end else begin
      rem_d = trial[COUNT_W-1:0];
    end
  end

  // Sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= busy_q && (step_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(QUO_W - 1);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == '0) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Dividend shifts out the top while quotient bits fill in at the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q     <= rem_init_i;
      work_q    <= dividend_i;
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      work_q <= {work_q[QUO_W-2:0], qbit};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = work_q;

endmodule

FILE: hw/rtl/d3r_dp.sv
module d3r_dp #(
  parameter int unsigned COORD_BITS = 12,
  localparam int unsigned IN_W  = ((d3r_pkg::DISP_W + 2 * COORD_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((4 * d3r_pkg::COORD_OUT_W + 2 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  d3r_pkg::cmd_t                     cmd_i,
  output d3r_pkg::status_t                  status_o,
  input  logic                              cfg_we_i,
  input  logic [d3r_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [d3r_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic [IN_W-1:0]                   in_data_i,
  input  logic                              in_last_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [OUT_W-1:0]                  out_data_o,
  output logic [1:0]                        out_user_o,
  output logic                              out_last_o
);
  import d3r_pkg::*;

  localparam int unsigned COL16_W = COORD_BITS + CENTER_FRAC;
  localparam int unsigned DX_W    = ((COL16_W > CENTER_W) ? COL16_W : CENTER_W) + 1;
  localparam int unsigned XP_W    = DX_W + K_W + 1;
  localparam int unsigned ZP_W    = FOCAL_W + K_W;
  localparam int unsigned ZS_W    = ZP_W - K_FRAC_BITS;

  // Configuration registers
  logic [MIN_DISP_W-1:0] min_disp_q;
  logic [FOCAL_W-1:0]    focal_q;
  logic [CENTER_W-1:0]   cx_q;
  logic [CENTER_W-1:0]   cy_q;
  logic [BASE_W-1:0]     base_q;

  // Item and intermediate registers
  logic [DISP_W-1:0]     in_disp;
  logic [COORD_BITS-1:0] in_col, in_row;
  logic                  pt_valid_d;
  logic [DX_W-1:0]       dx_d, dy_d;

  logic [DISP_W-1:0]     disp_q;
  logic [COORD_BITS-1:0] col_q, row_q;
  logic                  last_q;
  logic                  pt_valid_q;
  logic [DX_W-1:0]       dx_q, dy_q;
  logic [K_W-1:0]        k_q;
  logic [ZP_W-1:0]       zprod_q;
  logic signed [XP_W-1:0] xprod_q, yprod_q;
  logic [COORD_OUT_W-1:0] x_q, y_q, z_q;
  logic [COORD_OUT_W-1:0] mean_q;
  logic                  mean_valid_q;

  logic [SUM_W-1:0]      sum_q;
  logic [COUNT_W-1:0]    count_q;

  logic                  out_valid_q;
  logic [OUT_W-1:0]      out_data_q;
  logic [1:0]            out_user_q;
  logic                  out_last_q;

  // Divider operands
  logic                  div_start;
  logic [COUNT_W-1:0]    div_rem_init;
  logic [QUO_W-1:0]      div_dividend;
  logic [COUNT_W-1:0]    div_divisor;
  logic                  div_done;
  logic [QUO_W-1:0]      div_quo;

  // Saturation results
  logic [ZS_W-1:0]       z_shift;
  logic [COORD_OUT_W-1:0] z_sat, x_sat, y_sat;

  function automatic logic [COORD_OUT_W-1:0] sat_lat(input logic signed [XP_W-1:0] p);
    logic signed [XP_W-1:0] sh;
    logic [XP_W-COORD_OUT_W:0] top;
    sh  = p >>> CENTER_FRAC;
    top = sh[XP_W-1:COORD_OUT_W-1];
    if ((top == '0) || (top == '1)) begin
      return sh[COORD_OUT_W-1:0];
    end else if (sh[XP_W-1]) begin
      return {1'b1, {(COORD_OUT_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_OUT_W-1){1'b1}}};
    end
  endfunction

  // Write configuration; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_disp_q <= '0;
      focal_q    <= '0;
      cx_q       <= '0;
      cy_q       <= '0;
      base_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MIN_DISP: min_disp_q <= cfg_data_i[MIN_DISP_W-1:0];
        CFG_FOCAL:    focal_q    <= cfg_data_i[FOCAL_W-1:0];
        CFG_CENTER_X: cx_q       <= cfg_data_i[CENTER_W-1:0];
        CFG_CENTER_Y: cy_q       <= cfg_data_i[CENTER_W-1:0];
        CFG_BASELINE: base_q     <= cfg_data_i[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  // Unpack input, test the threshold and form the centered offsets
  always_comb begin
    in_disp    = in_data_i[DISP_W-1:0];
    in_col     = in_data_i[DISP_W +: COORD_BITS];
    in_row     = in_data_i[DISP_W + COORD_BITS +: COORD_BITS];
    pt_valid_d = $signed(in_disp) >
                 $signed({{(DISP_W-MIN_DISP_W-DISP_FRAC_BITS){1'b0}}, min_disp_q,
                          {DISP_FRAC_BITS{1'b0}}});
    dx_d = DX_W'({in_col, {CENTER_FRAC{1'b0}}}) - DX_W'(cx_q);
    dy_d = DX_W'({in_row, {CENTER_FRAC{1'b0}}}) - DX_W'(cy_q);
  end

  // Select divider operands: pixel scale or frame mean
  always_comb begin
    div_start = cmd_i.div_k_start | cmd_i.div_mean_start;
    if (cmd_i.div_mean_start) begin
      div_rem_init = sum_q[SUM_W-1:QUO_W];
      div_dividend = sum_q[QUO_W-1:0];
      div_divisor  = count_q;
    end else begin
      div_rem_init = '0;
      div_dividend = QUO_W'({base_q, {DISP_FRAC_BITS{1'b0}}});
      div_divisor  = COUNT_W'(disp_q[DISP_W-2:0]);
    end
  end

  d3r_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .rem_init_i (div_rem_init),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Saturate the products
  always_comb begin
    z_shift = zprod_q[ZP_W-1:K_FRAC_BITS];
    if (|z_shift[ZS_W-1:COORD_OUT_W]) begin
      z_sat = '1;
    end else begin
      z_sat = z_shift[COORD_OUT_W-1:0];
    end
    x_sat = sat_lat(xprod_q);
    y_sat = sat_lat(yprod_q);
  end

  // Item pipeline registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      disp_q       <= in_disp;
      col_q        <= in_col;
      row_q        <= in_row;
      last_q       <= in_last_i;
      pt_valid_q   <= pt_valid_d;
      dx_q         <= dx_d;
      dy_q         <= dy_d;
      mean_q       <= '0;
      mean_valid_q <= 1'b0;
    end
    if (cmd_i.k_load) begin
      k_q <= div_quo[K_W-1:0];
    end
    if (cmd_i.mul_load) begin
      zprod_q <= focal_q * k_q;
      xprod_q <= $signed(dx_q) * $signed({1'b0, k_q});
      yprod_q <= $signed(dy_q) * $signed({1'b0, k_q});
    end
    if (cmd_i.sat_load) begin
      x_q <= pt_valid_q ? x_sat : '0;
      y_q <= pt_valid_q ? y_sat : '0;
      z_q <= pt_valid_q ? z_sat : '0;
    end
    if (cmd_i.mean_load) begin
      mean_q       <= div_quo;
      mean_valid_q <= 1'b1;
    end
  end

  // Accumulate valid depths; clear once the frame result is loaded for output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
    end else if (cmd_i.out_load && last_q) begin
      sum_q   <= '0;
      count_q <= '0;
    end else if (cmd_i.sat_load && pt_valid_q && (count_q != COUNT_MAX)) begin
      sum_q   <= sum_q + SUM_W'(z_sat);
      count_q <= count_q + 1'b1;
    end
  end

  // Output register: holds a transaction until the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= OUT_W'({mean_q, row_q, col_q, z_q, y_q, x_q});
      out_user_q <= {mean_valid_q, pt_valid_q};
      out_last_q <= last_q;
    end
  end

  assign status_o.pt_valid = pt_valid_q;
  assign status_o.last     = last_q;
  assign status_o.count_nz = (count_q != '0);
  assign status_o.div_done = div_done;
  assign status_o.out_free = ~out_valid_q | out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;
  assign out_last_o  = out_last_q;

endmodule

FILE: hw/rtl/d3r_ctrl.sv
module d3r_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  d3r_pkg::status_t  status_i,
  output d3r_pkg::cmd_t     cmd_o
);
  import d3r_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Sequence one pixel: scale divide, products, saturate, frame mean, send
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status_i.pt_valid) begin
          cmd_o.div_k_start = 1'b1;
          state_d = ST_KDIV;
        end else begin
          state_d = ST_SAT;
        end
      end
      ST_KDIV: begin
        if (status_i.div_done) begin
          cmd_o.k_load = 1'b1;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul_load = 1'b1;
        state_d = ST_SAT;
      end
      ST_SAT: begin
        cmd_o.sat_load = 1'b1;
        state_d = status_i.last ? ST_FRAME : ST_OUT;
      end
      ST_FRAME: begin
        if (status_i.count_nz) begin
          cmd_o.div_mean_start = 1'b1;
          state_d = ST_MDIV;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_MDIV: begin
        if (status_i.div_done) begin
          cmd_o.mean_load = 1'b1;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/disparity_to_3d_reprojection.sv
// Stereo disparity to 3D point reprojection with a per-frame mean depth.
// Each accepted pixel yields exactly one result transaction. A pixel whose
// disparity exceeds the whole-pixel threshold times 16 is scaled by
// K = 16*baseline/disparity. K comes from a shared radix-2 divider that
// produces one quotient bit per cycle (32 steps). Z, X and Y are then formed
// in a multiply step and a saturate step. A valid pixel passes the check,
// divide, multiply and saturate states before the output register loads; an
// invalid one goes from the check straight to the saturate state. On the
// last pixel of a frame that held a valid point, the same divider computes
// the mean depth. The block is ready for the next pixel in the cycle after
// the output register loads, not before. A stalled sink holds the block
// until the previous result is taken. Configuration may only be written
// while the block is idle.
module disparity_to_3d_reprojection #(
  parameter int unsigned COORD_BITS = 12,
  localparam int unsigned IN_W  = ((d3r_pkg::DISP_W + 2 * COORD_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((4 * d3r_pkg::COORD_OUT_W + 2 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Pixel stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [IN_W-1:0]                 s_axis_tdata,  // disparity, col, row
  input  logic                            s_axis_tlast,  // frame_end
  // Result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [OUT_W-1:0]                m_axis_tdata,  // x_mm, y_mm, z_mm, point_col,
                                                         // point_row, mean_depth
  output logic [1:0]                      m_axis_tuser,  // point_valid, mean_valid
  output logic                            m_axis_tlast,  // frame_done
  // Configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [d3r_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [d3r_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import d3r_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Registers accept a write in every cycle
  assign cfg_ready_o = 1'b1;

  d3r_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  d3r_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule
